[rtl/modular_exponentiation_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation unit
// Implication assertions on the rising clock edge with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

`ifndef SYNTH

`define MODEXP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MODEXP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define MODEXP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/modexp_pkg.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Item types and the status bundle of the serial modular multiplier.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int FIELD_W = 32;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        t_field base_value;
        t_field exponent_value;
        t_field modulus_value;
    } t_in_item;

    typedef struct packed {
        t_field power_residue;
        logic   modulus_zero_error;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_sts;

endpackage

[rtl/modexp_mulmod.sv]
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Interleaved shift-and-add product x * y mod m, one bit of y per cycle,
// most significant bit first, with the reduction folded into every step.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_assert.svh"

module modexp_mulmod #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [W-1:0]       i_x,
    input  logic [W-1:0]       i_y,
    input  logic [W-1:0]       i_m,
    output logic [W-1:0]       o_prod,
    output modexp_pkg::t_mm_sts o_sts
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W+1:0]  w_sum;
    logic [W+1:0]  w_m1;
    logic [W+1:0]  w_m2;
    logic [W+1:0]  w_red;
    logic [W-1:0]  n_acc;

    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0} + (r_y[W-1] ? {2'b00, r_x} : {(W+2){1'b0}});
        w_m1  = {2'b00, r_m};
        w_m2  = {1'b0, r_m, 1'b0};
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        n_acc = w_red[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[W-2:0], 1'b0};
        end
    end

    assign o_prod      = r_acc;
    assign o_sts.busy  = r_busy;
    assign o_sts.done  = r_done;

    `MODEXP_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held longer than one cycle")
    `MODEXP_ASSERT_IMPLY(a_done_reduced, i_clk, i_rst_n, r_done, r_acc < r_m, "product not reduced")
    `MODEXP_ASSERT_IMPLY(a_cnt_live, i_clk, i_rst_n, r_busy && !i_start, r_cnt != '0, "busy with empty count")

endmodule

[rtl/modular_exponentiation_unit.sv]
// An item with a zero modulus goes from the idle state straight to the hold state, which
// loads the result. Otherwise the shared multiplier first reduces the base, then squares
// once per exponent bit up to the highest set bit and multiplies once per set bit, with
// the S_BIT dispatch state visited before each bit and the S_HOLD state at the end.
// Throughput: one item at a time; the next item may enter in the cycle after a result loads.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Right-to-left square-and-multiply over a shared bit-serial modular
// multiplier; the exponent is shifted out least significant bit first.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_assert.svh"

module modular_exponentiation_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  modexp_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output modexp_pkg::t_out_item o_out_item
);

    localparam int W  = OPERAND_WIDTH;
    localparam int FW = modexp_pkg::FIELD_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BASE = 6'b000010,
        S_BIT  = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [W-1:0]          r_acc, n_acc;
    logic [W-1:0]          r_pw, n_pw;
    logic [W-1:0]          r_exp, n_exp;
    logic [W-1:0]          r_m, n_m;
    logic                  r_err, n_err;
    logic                  r_ovalid, n_ovalid;
    modexp_pkg::t_out_item r_out, n_out;

    logic [W-1:0]          w_base;
    logic [W-1:0]          w_exp;
    logic [W-1:0]          w_mod;
    logic [W-1:0]          w_one;

    logic                  mm_start;
    logic [W-1:0]          mm_x;
    logic [W-1:0]          mm_y;
    logic [W-1:0]          mm_m;
    logic [W-1:0]          mm_prod;
    modexp_pkg::t_mm_sts   mm_sts;

    assign w_base = W'(i_in_item.base_value);
    assign w_exp  = W'(i_in_item.exponent_value);
    assign w_mod  = W'(i_in_item.modulus_value);
    assign w_one  = (w_mod == W'(1)) ? '0 : W'(1);

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_m     (mm_m),
        .o_prod  (mm_prod),
        .o_sts   (mm_sts)
    );

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_pw     = r_pw;
        n_exp    = r_exp;
        n_m      = r_m;
        n_err    = r_err;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        mm_start = 1'b0;
        mm_x     = r_acc;
        mm_y     = r_pw;
        mm_m     = r_m;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_m   = w_mod;
                    n_exp = w_exp;
                    if (w_mod == '0) begin
                        n_acc   = '0;
                        n_err   = 1'b1;
                        n_state = S_HOLD;
                    end else begin
                        n_acc    = w_one;
                        n_err    = 1'b0;
                        mm_start = 1'b1;
                        mm_x     = w_one;
                        mm_y     = w_base;
                        mm_m     = w_mod;
                        n_state  = S_BASE;
                    end
                end
            end
            S_BASE: begin
                if (mm_sts.done) begin
                    n_pw    = mm_prod;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                if (r_exp == '0) begin
                    n_state = S_HOLD;
                end else if (r_exp[0]) begin
                    mm_start = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    mm_start = 1'b1;
                    mm_x     = r_pw;
                    n_state  = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_sts.done) begin
                    n_acc    = mm_prod;
                    mm_start = 1'b1;
                    mm_x     = r_pw;
                    n_state  = S_SQR;
                end
            end
            S_SQR: begin
                if (mm_sts.done) begin
                    n_pw    = mm_prod;
                    n_exp   = r_exp >> 1;
                    n_state = S_BIT;
                end
            end
            S_HOLD: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid                 = 1'b1;
                    n_out.power_residue      = FW'(r_acc);
                    n_out.modulus_zero_error = r_err;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_pw  <= n_pw;
        r_exp <= n_exp;
        r_m   <= n_m;
        r_err <= n_err;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    `MODEXP_ASSERT_IMPLY(a_start_idle_mul, i_clk, i_rst_n, mm_start, !mm_sts.busy, "multiplier started while busy")
    `MODEXP_ASSERT_IMPLY(a_done_expected, i_clk, i_rst_n, mm_sts.done, (r_state == S_BASE) || (r_state == S_MUL) || (r_state == S_SQR), "product arrived in wrong state")
    `MODEXP_ASSERT_IMPLY(a_operands_reduced, i_clk, i_rst_n, r_state == S_BIT, (r_acc < r_m) && (r_pw < r_m), "operand not below modulus")
    `MODEXP_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, i_in_valid && !o_in_stall, (r_state == S_BASE) || (r_state == S_HOLD), "accepted item not started")

endmodule

[tb/modular_exponentiation_unit_tb.sv]
// ----------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Sends base, exponent and modulus items through the valid/stall channel and
// checks every result against a square-and-multiply predictor. The run covers
// directed edge cases first, then random items with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;

    localparam int OPERAND_WIDTH = 32;
    localparam int RANDOM_ITEMS = 280;
    localparam int SETTLE_CYCLES = 2300;
    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int MAX_PRINTED = 100;

    class residue_scoreboard;
        modexp_pkg::t_out_item pending_residues[$];
        int mismatches = 0;

        static function bit [63:0] mod_product(bit [63:0] a, bit [63:0] b, bit [63:0] m);
            return (a * b) % m;
        endfunction

        function modexp_pkg::t_out_item predict_power(modexp_pkg::t_in_item operands);
            modexp_pkg::t_out_item r;
            bit [63:0] m;
            bit [63:0] acc;
            bit [63:0] pw;
            bit [OPERAND_WIDTH-1:0] e;
            r = '0;
            m = 64'(operands.modulus_value);
            e = operands.exponent_value;
            if (m == 0) begin
                r.modulus_zero_error = 1'b1;
                return r;
            end
            acc = 64'd1 % m;
            pw = 64'(operands.base_value) % m;
            for (int k = 0; k < OPERAND_WIDTH; k++) begin
                if (e[k]) begin
                    acc = mod_product(acc, pw, m);
                end
                pw = mod_product(pw, pw, m);
            end
            r.power_residue = acc[31:0];
            return r;
        endfunction

        function void note_operands(modexp_pkg::t_in_item operands);
            pending_residues.push_back(predict_power(operands));
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
            mismatches++;
        endtask

        task check_residue(modexp_pkg::t_out_item got);
            modexp_pkg::t_out_item want;
            if (pending_residues.size() == 0) begin
                report($sformatf("result with no item pending: residue=%h error=%b",
                                 got.power_residue, got.modulus_zero_error));
                return;
            end
            want = pending_residues.pop_front();
            if (got.power_residue !== want.power_residue) begin
                report($sformatf("power_residue got %h, want %h",
                                 got.power_residue, want.power_residue));
            end
            if (got.modulus_zero_error !== want.modulus_zero_error) begin
                report($sformatf("modulus_zero_error got %b, want %b",
                                 got.modulus_zero_error, want.modulus_zero_error));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    modexp_pkg::t_in_item in_item = '0;
    logic in_stall;
    logic out_valid;
    modexp_pkg::t_out_item out_item;
    bit quiet = 1'b0;
    longint cycle_count = 0;
    residue_scoreboard sb = new();

    modular_exponentiation_unit #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_item(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item(out_item)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= !quiet && ($urandom_range(99) < 32);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_residue(out_item);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_operands(modexp_pkg::t_field b, modexp_pkg::t_field e,
                                 modexp_pkg::t_field m);
        modexp_pkg::t_in_item operands;
        operands.base_value = b;
        operands.exponent_value = e;
        operands.modulus_value = m;
        while (!quiet && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= operands;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sb.note_operands(operands);
    endtask

    initial begin
        modexp_pkg::t_field b;
        modexp_pkg::t_field e;
        modexp_pkg::t_field m;
        int pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero exponent, zero modulus and reduction corner cases.
        send_operands(32'd0, 32'd0, 32'd1);
        send_operands(32'd5, 32'd0, 32'd7);
        send_operands(32'd9, 32'd77, 32'd1);
        send_operands(32'd0, 32'd0, 32'd0);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_operands(32'd0, 32'd5, 32'd13);
        send_operands(32'd2, 32'd10, 32'd1000);
        send_operands(32'hFFFF_FFFF, 32'd1, 32'd2);
        send_operands(32'd13, 32'd3, 32'd13);
        send_operands(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFB);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'd3, 32'h8000_0000, 32'hFFFF_FFFF);
        send_operands(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_operands(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'd7, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
        send_operands(32'hFFFF_FFFE, 32'hAAAA_AAAA, 32'd3);
        send_operands(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);

        // Hold off until every outstanding result has drained.
        in_valid <= 1'b0;
        while (sb.pending_residues.size() != 0) begin
            @(posedge clk);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet <= (n >= 120 && n < 170);
            pick = $urandom_range(99);
            if (pick < 5) begin
                m = 32'd0;
            end else if (pick < 20) begin
                m = $urandom_range(16, 1);
            end else if (pick < 35) begin
                m = $urandom | 32'h8000_0000;
            end else begin
                m = $urandom;
            end
            b = ($urandom_range(3) == 0) ? modexp_pkg::t_field'($urandom_range(20))
                                         : modexp_pkg::t_field'($urandom);
            pick = $urandom_range(99);
            if (pick < 10) begin
                e = $urandom;
            end else if (pick < 30) begin
                e = $urandom & 32'h000F_FFFF;
            end else begin
                e = $urandom & (32'hFFFF_FFFF >> (32 - $urandom_range(10, 1)));
            end
            send_operands(b, e, m);
        end

        in_valid <= 1'b0;
        quiet <= 1'b0;
        while (sb.pending_residues.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
